// File: rtl/core/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the batch statistics engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MAX_VALUES_DEF = 256;
    localparam int RANK_FULL      = 25600;
    localparam int VAL_W          = 15;

    localparam logic [0:0] REQ_LOAD    = 1'b0;
    localparam logic [0:0] REQ_COMPUTE = 1'b1;

    localparam logic [0:0] CFG_POP_MODE = 1'b0;
    localparam logic [0:0] CFG_RANK     = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [14:0] score_value;
    } req_word_t;

    typedef struct packed {
        logic [8:0]  value_count;
        logic [14:0] mean_value;
        logic [14:0] median_value;
        logic [14:0] std_deviation;
        logic [14:0] percentile_value;
        logic        overflow_flag;
    } res_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_acc;    // clear sums and sort pass state
        logic acc_step;   // accumulate one stored entry
        logic sort_step;  // one compare/swap step
        logic fin_step;   // one step of the finishing sequence
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic acc_done;
        logic sort_done;
        logic fin_done;
    } dp_sts_t;

endpackage

// File: rtl/core/batch_statistics_engine.sv
// ----------------------------------------------------------------------------
// batch_statistics_engine
// Loads one score per cycle while idle; a compute request sorts the batch
// and reports count, mean, median, deviation and percentile, then empties it.
// ----------------------------------------------------------------------------
// a compute runs a bubble sort over the store (one read and one write port)
//   and a W-bit serial divider, W = 48 for 256 entries
// throughput: loads back to back; busy stays high through a compute
// reset: rst_n async low resets count, overflow mark and the control registers
// the result strobe lasts one cycle and the receiver cannot stall it
module batch_statistics_engine
#(
    parameter int MAX_VALUES = bse_pkg::MAX_VALUES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bse_pkg::req_word_t  req,
    output logic                done,
    output bse_pkg::res_word_t  result,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [14:0]         cfg_data
);

    logic              population_mode_reg;
    logic [14:0]       percentile_rank_reg;
    bse_pkg::dp_cmd_t  cmd;
    bse_pkg::dp_sts_t  sts;
    logic              acc, load, go, emit;

    assign acc  = start && !busy;
    assign load = acc && (req.req_type == bse_pkg::REQ_LOAD);
    assign go   = acc && (req.req_type == bse_pkg::REQ_COMPUTE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            population_mode_reg <= 1'b0;
            percentile_rank_reg <= 15'd12800;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bse_pkg::CFG_POP_MODE: population_mode_reg <= cfg_data[0];
                bse_pkg::CFG_RANK:     percentile_rank_reg <= cfg_data;
                default:               population_mode_reg <= population_mode_reg;
            endcase
        end
    end

    bse_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .emit  (emit)
    );

    bse_dp #(.MAX_VALUES(MAX_VALUES)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .score_value     (req.score_value),
        .population_mode (population_mode_reg),
        .percentile_rank (percentile_rank_reg),
        .cmd             (cmd),
        .emit            (emit),
        .sts             (sts),
        .res             (result)
    );

    assign done = emit;

endmodule

// File: rtl/core/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for a compute request: accumulate, sort, finish, emit.
// ----------------------------------------------------------------------------
module bse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  bse_pkg::dp_sts_t  sts,
    output bse_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              emit
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_SORT = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (go) state_next = ST_ACC;
            ST_ACC:  if (sts.acc_done) state_next = ST_SORT;
            ST_SORT: if (sts.sort_done) state_next = ST_FIN;
            ST_FIN:  if (sts.fin_done) state_next = ST_EMIT;
            ST_EMIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // command decode
    always_comb
    begin
        cmd.clr_acc   = (state_reg == ST_IDLE) && go;
        cmd.acc_step  = (state_reg == ST_ACC);
        cmd.sort_step = (state_reg == ST_SORT);
        cmd.fin_step  = (state_reg == ST_FIN);
    end

    assign busy = (state_reg != ST_IDLE);
    assign emit = (state_reg == ST_EMIT);

endmodule

// File: rtl/core/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// Store, sums, bubble sort, divider, square root and result assembly.
// ----------------------------------------------------------------------------
module bse_dp
#(
    parameter int MAX_VALUES = bse_pkg::MAX_VALUES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [14:0]              score_value,
    input  logic                     population_mode,
    input  logic [14:0]              percentile_rank,
    input  bse_pkg::dp_cmd_t         cmd,
    input  logic                     emit,
    output bse_pkg::dp_sts_t         sts,
    output bse_pkg::res_word_t       res
);

    localparam int IW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int S1W = CW + 15;
    localparam int S2W = CW + 30;
    localparam int NUMW = S2W + CW;
    localparam int DENW = 2 * CW;
    localparam int DIVW = NUMW;
    localparam int DCW = $clog2(DIVW + 1);

    // full rank is 1024 * 25: divide by 1024 with a shift, then by 25 with a
    // reciprocal multiply (exact for the operand ranges that occur here)
    localparam logic [21:0] RECIP_IDX  = 22'd167773;   // ceil(2^22 / 25)
    localparam logic [21:0] RECIP_FRAC = 22'd2684355;  // ceil(2^26 / 25)

    // finishing sequence steps
    localparam logic [3:0] F_MEAN_START = 4'd0;
    localparam logic [3:0] F_MEAN_WAIT  = 4'd1;
    localparam logic [3:0] F_MUL1       = 4'd2;
    localparam logic [3:0] F_MUL2       = 4'd3;
    localparam logic [3:0] F_VAR_START  = 4'd4;
    localparam logic [3:0] F_VAR_WAIT   = 4'd5;
    localparam logic [3:0] F_SQRT       = 4'd6;
    localparam logic [3:0] F_PCT_START  = 4'd7;
    localparam logic [3:0] F_PCT_WAIT   = 4'd8;
    localparam logic [3:0] F_MED_RD1    = 4'd9;
    localparam logic [3:0] F_MED_RD2    = 4'd10;
    localparam logic [3:0] F_PCT_RD1    = 4'd11;
    localparam logic [3:0] F_PCT_RD2    = 4'd12;
    localparam logic [3:0] F_PCT_MUL    = 4'd13;
    localparam logic [3:0] F_PCT_DIV    = 4'd14;
    localparam logic [3:0] F_DONE       = 4'd15;

    logic [14:0] mem [MAX_VALUES];
    logic [14:0] rd_reg;
    logic [CW-1:0] count_reg;
    logic dropped_reg;

    // store write, from loads or sort swaps
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [14:0]   wr_data;
    logic [IW-1:0] rd_addr;

    // accumulation
    logic [CW-1:0]  acc_idx_reg;
    logic           acc_vld_reg;
    logic [S1W-1:0] s1_reg;
    logic [S2W-1:0] s2_reg;
    logic [29:0]    sq_reg;
    logic           sq_vld_reg;
    logic [1:0]     acc_tail_reg;

    // sort: bubble passes with a carried maximum, a read and a write phase per element
    logic [CW-1:0] sort_i_reg;
    logic [CW-1:0] sort_pass_reg;
    logic          sort_ph_reg;
    logic [14:0]   carry_reg;
    logic          sort_fin_reg;
    logic          last_wr;
    logic          last_wr_d;
    logic [IW-1:0] last_addr_reg;

    // finishing
    logic [3:0]      fst_reg;
    logic [14:0]     mean_reg, med_reg, sd_reg, pct_reg;
    logic [14:0]     med_a_reg, lo_reg;
    logic [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic [S1W-1:0]  pct_idx_reg;
    logic [31:0]     pct_rem_reg;
    logic [31:0]     pmul_reg;
    logic [31:0]     pos_reg;
    logic [43:0]     idx_prod;
    logic [43:0]     frac_prod;

    // shared restoring divider
    logic [DIVW-1:0] dv_q_reg, dv_r_reg, dv_d_reg;
    logic [DCW-1:0]  dv_cnt_reg;
    logic            dv_busy_reg;
    logic            dv_start;
    logic [DIVW-1:0] dv_num, dv_den;

    // square root, two bits a step
    logic [DIVW-1:0] sq_x_reg, sq_root_reg, sq_bit_reg;

    logic          full;
    logic [CW-1:0] nm1;
    logic [14:0]   rank_sat;

    assign full = (count_reg == CW'(MAX_VALUES));
    assign nm1  = count_reg - CW'(1);
    assign rank_sat = (percentile_rank > 15'(bse_pkg::RANK_FULL)) ?
                      15'(bse_pkg::RANK_FULL) : percentile_rank;

    // count and overflow mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (emit)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (load)
        begin
            if (full)
                dropped_reg <= 1'b1;
            else
                count_reg <= count_reg + CW'(1);
        end
    end

    // sort control: pass p walks index 0..n-1-p, carrying the max upward
    logic [CW-1:0] sort_end;
    logic          sort_rd_ph;
    assign sort_end = count_reg - sort_pass_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_data = score_value;
        rd_addr = '0;
        if (load && !full)
            wr_en = 1'b1;
        if (cmd.acc_step)
            rd_addr = acc_idx_reg[IW-1:0];
        if (cmd.sort_step)
        begin
            rd_addr = sort_i_reg[IW-1:0];
            if (last_wr_d)
            begin
                // carried max lands at the end of the finished pass
                wr_en   = 1'b1;
                wr_addr = last_addr_reg;
                wr_data = carry_reg;
            end
            else if (sort_ph_reg && sort_i_reg != '0)
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(sort_i_reg - CW'(1));
                wr_data = (rd_reg < carry_reg) ? rd_reg : carry_reg;
            end
        end
        if (cmd.fin_step)
        begin
            case (fst_reg)
                F_MED_RD1: rd_addr = IW'((count_reg >> 1) - CW'(1));
                F_MED_RD2: rd_addr = IW'(count_reg >> 1);
                F_PCT_RD1: rd_addr = IW'(pct_idx_reg);
                F_PCT_RD2: rd_addr = IW'(pct_idx_reg + S1W'(1));
                default:   rd_addr = IW'(count_reg >> 1);
            endcase
        end
    end
    assign sort_rd_ph = sort_ph_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // accumulate sums over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_idx_reg  <= '0;
            acc_vld_reg  <= 1'b0;
            sq_vld_reg   <= 1'b0;
            acc_tail_reg <= '0;
        end
        else if (cmd.clr_acc)
        begin
            acc_idx_reg  <= '0;
            acc_vld_reg  <= 1'b0;
            sq_vld_reg   <= 1'b0;
            acc_tail_reg <= '0;
        end
        else if (cmd.acc_step)
        begin
            acc_vld_reg <= (acc_idx_reg < count_reg);
            sq_vld_reg  <= acc_vld_reg;
            if (acc_idx_reg < count_reg)
                acc_idx_reg <= acc_idx_reg + CW'(1);
            else
                acc_tail_reg <= acc_tail_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (cmd.acc_step)
        begin
            sq_reg <= 30'(rd_reg) * 30'(rd_reg);
            if (acc_vld_reg)
                s1_reg <= s1_reg + S1W'(rd_reg);
            if (sq_vld_reg)
                s2_reg <= s2_reg + S2W'(sq_reg);
        end
    end

    assign sts.acc_done = cmd.acc_step && (acc_tail_reg == 2'd2);

    // sort sequencing: read phase then write phase per element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_i_reg    <= '0;
            sort_pass_reg <= '0;
            sort_ph_reg   <= 1'b0;
            sort_fin_reg  <= 1'b0;
        end
        else if (cmd.clr_acc)
        begin
            sort_i_reg    <= '0;
            sort_pass_reg <= '0;
            sort_ph_reg   <= 1'b0;
            sort_fin_reg  <= 1'b0;
        end
        else if (cmd.sort_step)
        begin
            if (count_reg < CW'(2) || sort_pass_reg >= nm1)
                sort_fin_reg <= 1'b1;
            else if (!sort_rd_ph)
                sort_ph_reg <= 1'b1;
            else
            begin
                sort_ph_reg <= 1'b0;
                if (sort_i_reg == sort_end - CW'(1))
                begin
                    sort_i_reg    <= '0;
                    sort_pass_reg <= sort_pass_reg + CW'(1);
                end
                else
                    sort_i_reg <= sort_i_reg + CW'(1);
            end
        end
    end

    // carried maximum
    assign last_wr = cmd.sort_step && sort_ph_reg && !sort_fin_reg &&
                     !(count_reg < CW'(2) || sort_pass_reg >= nm1) &&
                     (sort_i_reg == sort_end - CW'(1));
    always_ff @(posedge clk)
    begin
        if (cmd.sort_step && sort_ph_reg)
        begin
            if (sort_i_reg == '0)
                carry_reg <= rd_reg;
            else
                carry_reg <= (rd_reg < carry_reg) ? carry_reg : rd_reg;
        end
    end

    // write the carried max to the pass end in the following cycle, during the
    // read phase of the next pass or the cycle that ends the sort
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_wr_d <= 1'b0;
        else
            last_wr_d <= last_wr;
    end
    always_ff @(posedge clk)
    begin
        if (last_wr)
            last_addr_reg <= sort_i_reg[IW-1:0];
    end

    assign sts.sort_done = cmd.sort_step && sort_fin_reg;

    // divider
    always_comb
    begin
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = '0;
        if (cmd.fin_step)
        begin
            case (fst_reg)
                F_MEAN_START:
                begin
                    dv_start = 1'b1;
                    dv_num   = DIVW'(s1_reg);
                    dv_den   = DIVW'(count_reg);
                end
                F_VAR_START:
                begin
                    dv_start = 1'b1;
                    dv_num   = DIVW'(num_reg);
                    dv_den   = DIVW'(den_reg);
                end
                default: dv_start = 1'b0;
            endcase
        end
    end

    logic [DIVW:0] dv_trial;
    assign dv_trial = {dv_r_reg, dv_q_reg[DIVW-1]} - {1'b0, dv_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (dv_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= DCW'(DIVW);
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - DCW'(1);
            if (dv_cnt_reg == DCW'(1))
                dv_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_start)
        begin
            dv_q_reg <= dv_num;
            dv_r_reg <= '0;
            dv_d_reg <= dv_den;
        end
        else if (dv_busy_reg)
        begin
            if (!dv_trial[DIVW])
            begin
                dv_r_reg <= dv_trial[DIVW-1:0];
                dv_q_reg <= {dv_q_reg[DIVW-2:0], 1'b1};
            end
            else
            begin
                dv_r_reg <= {dv_r_reg[DIVW-2:0], dv_q_reg[DIVW-1]};
                dv_q_reg <= {dv_q_reg[DIVW-2:0], 1'b0};
            end
        end
    end

    // percentile index and fraction by reciprocal multiply
    assign idx_prod  = 44'(pos_reg[31:10]) * 44'(RECIP_IDX);
    assign frac_prod = 44'(pmul_reg[31:10]) * 44'(RECIP_FRAC);

    // finishing sequence
    logic [DIVW-1:0] sq_sum;
    assign sq_sum = sq_root_reg + sq_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fst_reg <= F_MEAN_START;
        else if (cmd.clr_acc)
            fst_reg <= F_MEAN_START;
        else if (cmd.fin_step)
        begin
            case (fst_reg)
                F_MEAN_START: fst_reg <= F_MEAN_WAIT;
                F_MEAN_WAIT:  if (!dv_busy_reg) fst_reg <= F_MUL1;
                F_MUL1:       fst_reg <= F_MUL2;
                F_MUL2:       fst_reg <= F_VAR_START;
                F_VAR_START:  fst_reg <= F_VAR_WAIT;
                F_VAR_WAIT:   if (!dv_busy_reg) fst_reg <= F_SQRT;
                F_SQRT:       if (sq_bit_reg == '0) fst_reg <= F_PCT_START;
                F_PCT_START:  fst_reg <= F_PCT_WAIT;
                F_PCT_WAIT:   fst_reg <= F_MED_RD1;
                F_MED_RD1:    fst_reg <= F_MED_RD2;
                F_MED_RD2:    fst_reg <= F_PCT_RD1;
                F_PCT_RD1:    fst_reg <= F_PCT_RD2;
                F_PCT_RD2:    fst_reg <= F_PCT_MUL;
                F_PCT_MUL:    fst_reg <= F_PCT_DIV;
                F_PCT_DIV:    fst_reg <= F_DONE;
                default:      fst_reg <= F_DONE;
            endcase
        end
    end

    assign sts.fin_done = cmd.fin_step && (fst_reg == F_DONE);

    logic [S2W+CW-1:0] ns2;
    logic [2*S1W-1:0]  s1sq;
    logic [14:0]       diff;
    logic [14:0]       hi_v;
    assign hi_v = rd_reg;
    assign diff = hi_v - lo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin_step)
        begin
            case (fst_reg)
                F_MEAN_WAIT:
                    if (!dv_busy_reg)
                        mean_reg <= (count_reg == '0) ? 15'd0 : dv_q_reg[14:0];
                F_MUL1:
                begin
                    ns2  <= (S2W+CW)'(s2_reg) * (S2W+CW)'(count_reg);
                    s1sq <= (2*S1W)'(s1_reg) * (2*S1W)'(s1_reg);
                    den_reg <= DENW'(count_reg) *
                               DENW'(population_mode ? count_reg : nm1);
                end
                F_MUL2:
                    num_reg <= NUMW'(ns2) - NUMW'(s1sq);
                F_VAR_WAIT:
                    if (!dv_busy_reg)
                    begin
                        sq_x_reg    <= dv_q_reg;
                        sq_root_reg <= '0;
                        sq_bit_reg  <= DIVW'(1) << (2 * ((DIVW - 1) / 2));
                    end
                F_SQRT:
                begin
                    if (sq_bit_reg != '0)
                    begin
                        if (sq_x_reg >= sq_sum)
                        begin
                            sq_x_reg    <= sq_x_reg - sq_sum;
                            sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                        end
                        else
                            sq_root_reg <= sq_root_reg >> 1;
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                    else
                        sd_reg <= (count_reg < CW'(2)) ? 15'd0 :
                                  (sq_root_reg > DIVW'(15'h7FFF)) ? 15'h7FFF :
                                  sq_root_reg[14:0];
                end
                F_PCT_START:
                    pos_reg <= 32'(rank_sat) * 32'(nm1);
                F_PCT_WAIT:
                    pct_idx_reg <= S1W'(idx_prod[43:22]);
                F_MED_RD1:
                    pct_rem_reg <= pos_reg -
                                   32'(pct_idx_reg) * 32'(bse_pkg::RANK_FULL);
                F_MED_RD2: med_a_reg <= rd_reg;
                F_PCT_RD1:
                    med_reg <= count_reg[0] ? rd_reg :
                               15'(({1'b0, med_a_reg} + {1'b0, rd_reg}) >> 1);
                F_PCT_RD2: lo_reg <= rd_reg;
                F_PCT_MUL:
                    pmul_reg <= pct_rem_reg * 32'(diff);
                F_PCT_DIV:
                begin
                    if (count_reg == '0)
                        pct_reg <= '0;
                    else if (pct_idx_reg >= S1W'(nm1))
                        pct_reg <= lo_reg;
                    else
                        pct_reg <= lo_reg + frac_prod[40:26];
                end
                default: pct_reg <= pct_reg;
            endcase
        end
    end

    // result word
    always_comb
    begin
        res.value_count      = (count_reg > CW'(511)) ? 9'd511 : 9'(count_reg);
        res.mean_value       = (count_reg == '0) ? 15'd0 : mean_reg;
        res.median_value     = (count_reg == '0) ? 15'd0 : med_reg;
        res.std_deviation    = sd_reg;
        res.percentile_value = pct_reg;
        res.overflow_flag    = dropped_reg;
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the batch statistics engine: drives loads, compute
// requests and register writes, predicts every result word and checks each field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_N       = bse_pkg::MAX_VALUES_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    bse_pkg::req_word_t req;
    logic      done;
    bse_pkg::res_word_t result;
    logic      cfg_we;
    logic [0:0] cfg_index;
    logic [14:0] cfg_data;

    // predictor state
    logic [14:0] batch_scores [MAX_N];
    int unsigned batch_len;
    logic        batch_dropped;
    logic        pop_mode;
    logic [14:0] rank_q78;

    bse_pkg::res_word_t pending_stats[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned words_sent;
    int unsigned stats_seen;
    int unsigned reg_writes;

    batch_statistics_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // statistics of the current batch, as the block should report them
    function automatic bse_pkg::res_word_t batch_stats();
        bse_pkg::res_word_t r;
        longint unsigned srt [MAX_N];
        longint unsigned s1, s2, num, dv, sd, rk, pos, idx, rem, lo, hi, pct, key;
        int unsigned n, i, j;
        n = batch_len;
        r = '0;
        s1 = 0;
        s2 = 0;
        if (n > 0)
        begin
            for (i = 0; i < n; i++)
            begin
                srt[i] = batch_scores[i];
                s1 += srt[i];
                s2 += srt[i] * srt[i];
            end
            // insertion sort
            for (i = 1; i < n; i++)
            begin
                key = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > key)
                begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = key;
            end
            r.mean_value = 15'(s1 / n);
            if (n % 2 == 0)
                r.median_value = 15'((srt[n/2-1] + srt[n/2]) >> 1);
            else
                r.median_value = 15'(srt[n/2]);
            if (n >= 2)
            begin
                dv  = pop_mode ? n : n - 1;
                num = longint'(n) * s2 - s1 * s1;
                sd  = int_sqrt(num / (longint'(n) * dv));
                r.std_deviation = (sd > 32767) ? 15'h7fff : 15'(sd);
            end
            rk  = (rank_q78 > bse_pkg::RANK_FULL) ? bse_pkg::RANK_FULL : rank_q78;
            pos = rk * (n - 1);
            idx = pos / bse_pkg::RANK_FULL;
            rem = pos % bse_pkg::RANK_FULL;
            if (idx >= n - 1)
                pct = srt[n-1];
            else
            begin
                lo  = srt[idx];
                hi  = srt[idx+1];
                pct = lo + (rem * (hi - lo)) / bse_pkg::RANK_FULL;
            end
            r.percentile_value = 15'(pct);
        end
        r.value_count   = (n > 511) ? 9'd511 : 9'(n);
        r.overflow_flag = batch_dropped;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        bse_pkg::res_word_t want;
        if (rst_n && done)
        begin
            stats_seen++;
            if (pending_stats.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                if (result.value_count !== want.value_count)
                begin
                    $error("value_count exp %0d got %0d", want.value_count, result.value_count);
                    fail_count++;
                end
                if (result.mean_value !== want.mean_value)
                begin
                    $error("mean_value exp %0d got %0d", want.mean_value, result.mean_value);
                    fail_count++;
                end
                if (result.median_value !== want.median_value)
                begin
                    $error("median_value exp %0d got %0d", want.median_value,
                           result.median_value);
                    fail_count++;
                end
                if (result.std_deviation !== want.std_deviation)
                begin
                    $error("std_deviation exp %0d got %0d", want.std_deviation,
                           result.std_deviation);
                    fail_count++;
                end
                if (result.percentile_value !== want.percentile_value)
                begin
                    $error("percentile_value exp %0d got %0d", want.percentile_value,
                           result.percentile_value);
                    fail_count++;
                end
                if (result.overflow_flag !== want.overflow_flag)
                begin
                    $error("overflow_flag exp %0d got %0d", want.overflow_flag,
                           result.overflow_flag);
                    fail_count++;
                end
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // send one request word and update the predictor once it is taken
    task automatic send_word(input logic [0:0] kind, input logic [14:0] score);
        bse_pkg::req_word_t w;
        int unsigned gap;
        w.req_type    = kind;
        w.score_value = score;
        @(negedge clk);
        start = 1'b1;
        req   = w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (kind == bse_pkg::REQ_LOAD)
        begin
            if (batch_len < MAX_N)
            begin
                batch_scores[batch_len] = score;
                batch_len++;
            end
            else
                batch_dropped = 1'b1;
        end
        else
        begin
            pending_stats.push_back(batch_stats());
            batch_len     = 0;
            batch_dropped = 1'b0;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // hold off until every expected word is back and the block is idle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_stats.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [14:0] data);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_writes++;
        if (idx == bse_pkg::CFG_POP_MODE)
            pop_mode = data[0];
        else
            rank_q78 = data;
    endtask

    task automatic load_batch(input int unsigned n, input int unsigned vmax);
        for (int unsigned i = 0; i < n; i++)
            send_word(bse_pkg::REQ_LOAD, 15'($urandom_range(0, vmax)));
    endtask

    // empty batch, single value and the field extremes
    task automatic test_edges();
        send_word(bse_pkg::REQ_COMPUTE, 15'h7fff);
        send_word(bse_pkg::REQ_LOAD, 15'h7fff);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'd25600);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'h7fff);
        send_word(bse_pkg::REQ_LOAD, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'h7fff);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'h5555);
        send_word(bse_pkg::REQ_LOAD, 15'h2aaa);
        send_word(bse_pkg::REQ_LOAD, 15'd1);
        send_word(bse_pkg::REQ_LOAD, 15'h5555);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
    endtask

    // register extremes, including a rank past full scale
    task automatic test_registers();
        logic [14:0] ranks [6];
        ranks = '{15'd0, 15'd1, 15'd25599, 15'd25600, 15'h7fff, 15'd12800};
        for (int m = 1; m >= 0; m--)
        begin
            write_reg(bse_pkg::CFG_POP_MODE, 15'(m));
            foreach (ranks[k])
            begin
                write_reg(bse_pkg::CFG_RANK, ranks[k]);
                load_batch($urandom_range(2, 6), 32767);
                send_word(bse_pkg::REQ_COMPUTE, 15'd0);
            end
        end
    endtask

    // full batch with dropped loads, a clean batch after it, then a batch of exactly the depth
    task automatic test_overflow();
        write_reg(bse_pkg::CFG_POP_MODE, 15'd1);
        load_batch(MAX_N + 3, 32767);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
        send_word(bse_pkg::REQ_LOAD, 15'd100);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
        write_reg(bse_pkg::CFG_POP_MODE, 15'd0);
        load_batch(MAX_N, 25600);
        send_word(bse_pkg::REQ_COMPUTE, 15'd0);
    endtask

    // random batches with random content and occasional register changes
    task automatic test_random();
        int unsigned base, sz, vmax, p, dup;
        base = words_sent;
        while (words_sent - base < 40)
        begin
            p = $urandom_range(0, 99);
            if (p < 8)
                write_reg(bse_pkg::CFG_RANK, 15'($urandom_range(0, 32767)));
            else if (p < 14)
                write_reg(bse_pkg::CFG_POP_MODE, 15'($urandom_range(0, 1)));
            else if (p < 18)
                drain();
            p = $urandom_range(0, 99);
            sz = (p < 85) ? $urandom_range(0, 10) : $urandom_range(11, 40);
            vmax = ($urandom_range(0, 3) == 0) ? 32767 : 25600;
            dup = $urandom_range(0, vmax);
            for (int unsigned i = 0; i < sz; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_word(bse_pkg::REQ_LOAD, 15'(dup));
                else
                    send_word(bse_pkg::REQ_LOAD, 15'($urandom_range(0, vmax)));
            end
            send_word(bse_pkg::REQ_COMPUTE, 15'($urandom_range(0, 32767)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        batch_len     = 0;
        batch_dropped = 1'b0;
        pop_mode      = 1'b0;
        rank_q78      = 15'd12800;
        fail_count    = 0;
        cycle_count   = 0;
        words_sent    = 0;
        stats_seen    = 0;
        reg_writes    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edges();
        test_registers();
        test_overflow();
        test_random();
        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d request words, %0d result words, %0d register writes",
                 words_sent, stats_seen, reg_writes);
        $display("empty, single, full and overflowing batches; both divisors; rank extremes");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: batch_statistics_engine.f
rtl/core/bse_pkg.sv
rtl/core/bse_ctrl.sv
rtl/core/bse_dp.sv
rtl/core/batch_statistics_engine.sv
test/testbench.sv
